@@ src/apvr_pkg.sv @@
// Shared types and constants for the affine point/vector/ray transform.
// No dependencies; every other file in src/ but apvr_checker.sv uses this package.
`default_nettype none

package apvr_pkg;

  localparam int COEF_W   = 32;   // one Q16.16 matrix coefficient
  localparam int FIELD_W  = 32;   // coordinate fields on the channels
  localparam int REG_W    = 64;   // one configuration register, two coefficients
  localparam int NUM_REGS = 6;
  localparam int IDX_W    = 3;
  localparam int OP_W     = 2;
  localparam int ROWS     = 3;
  localparam int COLS     = 4;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef coef_t [ROWS-1:0][COLS-1:0] coef_mat_t;
  typedef logic [OP_W-1:0] op_t;
  typedef logic [IDX_W-1:0] reg_idx_t;

  localparam op_t OP_POINT  = 2'd0;
  localparam op_t OP_VECTOR = 2'd1;
  localparam op_t OP_RAY    = 2'd2;

  localparam reg_idx_t REG_ROW0_A = 3'd0;
  localparam reg_idx_t REG_ROW0_B = 3'd1;
  localparam reg_idx_t REG_ROW1_A = 3'd2;
  localparam reg_idx_t REG_ROW1_B = 3'd3;
  localparam reg_idx_t REG_ROW2_A = 3'd4;
  localparam reg_idx_t REG_ROW2_B = 3'd5;

  // identity matrix, no translation
  localparam logic [REG_W-1:0] RST_ROW0_A = 64'h0000_0000_0001_0000;
  localparam logic [REG_W-1:0] RST_ROW0_B = 64'h0000_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_ROW1_A = 64'h0001_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_ROW1_B = 64'h0000_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_ROW2_A = 64'h0000_0000_0000_0000;
  localparam logic [REG_W-1:0] RST_ROW2_B = 64'h0000_0000_0001_0000;

endpackage

`default_nettype wire

@@ src/apvr_if.sv @@
// Channel interfaces: item input, result output and register write port.
// Depends on apvr_pkg for field widths.
`default_nettype none

interface apvr_in_if;
  logic                                valid;
  logic                                ready;
  logic [apvr_pkg::OP_W-1:0]           opcode;
  logic signed [apvr_pkg::FIELD_W-1:0] origin_x;
  logic signed [apvr_pkg::FIELD_W-1:0] origin_y;
  logic signed [apvr_pkg::FIELD_W-1:0] origin_z;
  logic signed [apvr_pkg::FIELD_W-1:0] dir_x;
  logic signed [apvr_pkg::FIELD_W-1:0] dir_y;
  logic signed [apvr_pkg::FIELD_W-1:0] dir_z;

  modport source(output valid, opcode, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                 input ready);
  modport sink(input valid, opcode, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
               output ready);
endinterface

interface apvr_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [apvr_pkg::FIELD_W-1:0] out_origin_x;
  logic signed [apvr_pkg::FIELD_W-1:0] out_origin_y;
  logic signed [apvr_pkg::FIELD_W-1:0] out_origin_z;
  logic signed [apvr_pkg::FIELD_W-1:0] out_dir_x;
  logic signed [apvr_pkg::FIELD_W-1:0] out_dir_y;
  logic signed [apvr_pkg::FIELD_W-1:0] out_dir_z;
  logic                                saturated;

  modport source(output valid, out_origin_x, out_origin_y, out_origin_z,
                 out_dir_x, out_dir_y, out_dir_z, saturated, input ready);
  modport sink(input valid, out_origin_x, out_origin_y, out_origin_z,
               out_dir_x, out_dir_y, out_dir_z, saturated, output ready);
endinterface

interface apvr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [apvr_pkg::IDX_W-1:0]      index;
  logic [apvr_pkg::REG_W-1:0]      data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/apvr_coef_regs.sv @@
// Coefficient register file: six 64-bit registers, two coefficients each.
// Depends on apvr_pkg and apvr_cfg_if.
`default_nettype none

module apvr_coef_regs (
  input  wire logic               clk,
  input  wire logic               rst_n,
  apvr_cfg_if.sink                cfg,
  output apvr_pkg::coef_mat_t     coefs
);

  logic [apvr_pkg::REG_W-1:0] reg_r [apvr_pkg::NUM_REGS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_r[0] <= apvr_pkg::RST_ROW0_A;
      reg_r[1] <= apvr_pkg::RST_ROW0_B;
      reg_r[2] <= apvr_pkg::RST_ROW1_A;
      reg_r[3] <= apvr_pkg::RST_ROW1_B;
      reg_r[4] <= apvr_pkg::RST_ROW2_A;
      reg_r[5] <= apvr_pkg::RST_ROW2_B;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        apvr_pkg::REG_ROW0_A: reg_r[0] <= cfg.data;
        apvr_pkg::REG_ROW0_B: reg_r[1] <= cfg.data;
        apvr_pkg::REG_ROW1_A: reg_r[2] <= cfg.data;
        apvr_pkg::REG_ROW1_B: reg_r[3] <= cfg.data;
        apvr_pkg::REG_ROW2_A: reg_r[4] <= cfg.data;
        apvr_pkg::REG_ROW2_B: reg_r[5] <= cfg.data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // row r: first register holds m[r][0] low / m[r][1] high,
  // second holds m[r][2] low / translation m[r][3] high
  always_comb begin
    for (int r = 0; r < apvr_pkg::ROWS; r++) begin
      coefs[r][0] = reg_r[2*r][31:0];
      coefs[r][1] = reg_r[2*r][63:32];
      coefs[r][2] = reg_r[2*r+1][31:0];
      coefs[r][3] = reg_r[2*r+1][63:32];
    end
  end

endmodule

`default_nettype wire

@@ src/apvr_row_pipe.sv @@
// One matrix row against one coordinate triple: product stage, sum stage,
// then saturation to COORD_WIDTH bits. Depends on apvr_pkg.
`default_nettype none

module apvr_row_pipe #(
  parameter int       FRAC_BITS   = 16,
  parameter int       COORD_WIDTH = 32,
  parameter bit       WITH_T      = 1'b1
) (
  input  wire logic                          clk,
  input  wire logic                          prod_en,
  input  wire logic                          sum_en,
  input  wire apvr_pkg::coef_t               m0,
  input  wire apvr_pkg::coef_t               m1,
  input  wire apvr_pkg::coef_t               m2,
  input  wire apvr_pkg::coef_t               t,
  input  wire logic signed [COORD_WIDTH-1:0] c0,
  input  wire logic signed [COORD_WIDTH-1:0] c1,
  input  wire logic signed [COORD_WIDTH-1:0] c2,
  output logic signed [COORD_WIDTH-1:0]      res,
  output logic                               sat
);

  localparam int PROD_W = apvr_pkg::COEF_W + COORD_WIDTH;
  localparam int SH_W   = PROD_W - FRAC_BITS;
  localparam int SUM_W  = ((SH_W > apvr_pkg::COEF_W) ? SH_W : apvr_pkg::COEF_W) + 2;

  logic signed [PROD_W-1:0] p0_r, p1_r, p2_r;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic signed [SUM_W-1:0]  t_ext;
  logic                     ovf;

  always_ff @(posedge clk) begin
    if (prod_en) begin
      p0_r <= $signed(m0) * c0;
      p1_r <= $signed(m1) * c1;
      p2_r <= $signed(m2) * c2;
    end
  end

  assign t_ext = WITH_T ? SUM_W'($signed(t)) : '0;

  // dropping the low fraction bits floors toward minus infinity
  assign sum_nxt = SUM_W'($signed(p0_r[PROD_W-1:FRAC_BITS]))
                 + SUM_W'($signed(p1_r[PROD_W-1:FRAC_BITS]))
                 + SUM_W'($signed(p2_r[PROD_W-1:FRAC_BITS]))
                 + t_ext;

  always_ff @(posedge clk) begin
    if (sum_en) begin
      sum_r <= sum_nxt;
    end
  end

  // out of range when the bits above the result's sign disagree with it
  assign ovf = (sum_r[SUM_W-1:COORD_WIDTH-1] != '0) && (sum_r[SUM_W-1:COORD_WIDTH-1] != '1);
  assign sat = ovf;

  always_comb begin
    if (!ovf) begin
      res = sum_r[COORD_WIDTH-1:0];
    end else if (sum_r[SUM_W-1]) begin
      res = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      res = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

@@ src/affine_point_vector_ray_transform.sv @@
// 3x4 affine transform of a point, a direction vector or a ray, Q16.16.
// Each accepted word passes the input reg, product reg, row-sum reg and output
// reg in turn. Throughput: one word per cycle; each stage refills as it drains,
// so only a stalled output holds the pipe.
// Reset (synchronous, rst_n low) empties the pipe and loads the identity matrix.
`default_nettype none

module affine_point_vector_ray_transform #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  apvr_in_if.sink     in_ch,
  apvr_out_if.source  out_ch,
  apvr_cfg_if.sink    cfg_ch
);

  localparam int FW = apvr_pkg::FIELD_W;

  apvr_pkg::coef_mat_t coefs;

  apvr_coef_regs u_coef_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_ch),
    .coefs (coefs)
  );

  // stage valids and ready chain
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_r || out_ch.ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_ch.valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // stage 1: input word, coordinates cut to COORD_WIDTH
  apvr_pkg::op_t                  op1_r, op2_r, op3_r;
  logic signed [COORD_WIDTH-1:0]  org1_r [apvr_pkg::ROWS];
  logic signed [COORD_WIDTH-1:0]  dir1_r [apvr_pkg::ROWS];

  always_ff @(posedge clk) begin
    if (rdy1) begin
      op1_r     <= in_ch.opcode;
      org1_r[0] <= in_ch.origin_x[COORD_WIDTH-1:0];
      org1_r[1] <= in_ch.origin_y[COORD_WIDTH-1:0];
      org1_r[2] <= in_ch.origin_z[COORD_WIDTH-1:0];
      dir1_r[0] <= in_ch.dir_x[COORD_WIDTH-1:0];
      dir1_r[1] <= in_ch.dir_y[COORD_WIDTH-1:0];
      dir1_r[2] <= in_ch.dir_z[COORD_WIDTH-1:0];
    end
    if (rdy2) op2_r <= op1_r;
    if (rdy3) op3_r <= op2_r;
  end

  // stages 2 and 3: six row units
  logic signed [COORD_WIDTH-1:0] org_res [apvr_pkg::ROWS];
  logic signed [COORD_WIDTH-1:0] dir_res [apvr_pkg::ROWS];
  logic [apvr_pkg::ROWS-1:0]     org_sat, dir_sat;

  for (genvar r = 0; r < apvr_pkg::ROWS; r++) begin : g_row
    apvr_row_pipe #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH),
      .WITH_T      (1'b1)
    ) u_org (
      .clk     (clk),
      .prod_en (rdy2),
      .sum_en  (rdy3),
      .m0      (coefs[r][0]),
      .m1      (coefs[r][1]),
      .m2      (coefs[r][2]),
      .t       (coefs[r][3]),
      .c0      (org1_r[0]),
      .c1      (org1_r[1]),
      .c2      (org1_r[2]),
      .res     (org_res[r]),
      .sat     (org_sat[r])
    );

    apvr_row_pipe #(
      .FRAC_BITS   (FRAC_BITS),
      .COORD_WIDTH (COORD_WIDTH),
      .WITH_T      (1'b0)
    ) u_dir (
      .clk     (clk),
      .prod_en (rdy2),
      .sum_en  (rdy3),
      .m0      (coefs[r][0]),
      .m1      (coefs[r][1]),
      .m2      (coefs[r][2]),
      .t       (coefs[r][3]),
      .c0      (dir1_r[0]),
      .c1      (dir1_r[1]),
      .c2      (dir1_r[2]),
      .res     (dir_res[r]),
      .sat     (dir_sat[r])
    );
  end

  // stage 4: select by opcode, zero the unused half
  logic              org_on, dir_on;
  logic signed [FW-1:0] org4_nxt [apvr_pkg::ROWS];
  logic signed [FW-1:0] dir4_nxt [apvr_pkg::ROWS];
  logic signed [FW-1:0] org4_r   [apvr_pkg::ROWS];
  logic signed [FW-1:0] dir4_r   [apvr_pkg::ROWS];
  logic                 sat4_nxt, sat4_r;

  assign org_on = (op3_r == apvr_pkg::OP_POINT)  || (op3_r == apvr_pkg::OP_RAY);
  assign dir_on = (op3_r == apvr_pkg::OP_VECTOR) || (op3_r == apvr_pkg::OP_RAY);

  always_comb begin
    for (int r = 0; r < apvr_pkg::ROWS; r++) begin
      org4_nxt[r] = org_on ? FW'(org_res[r]) : '0;
      dir4_nxt[r] = dir_on ? FW'(dir_res[r]) : '0;
    end
    sat4_nxt = (org_on && (|org_sat)) || (dir_on && (|dir_sat));
  end

  always_ff @(posedge clk) begin
    if (rdy4) begin
      org4_r <= org4_nxt;
      dir4_r <= dir4_nxt;
      sat4_r <= sat4_nxt;
    end
  end

  assign out_ch.valid        = v4_r;
  assign out_ch.out_origin_x = org4_r[0];
  assign out_ch.out_origin_y = org4_r[1];
  assign out_ch.out_origin_z = org4_r[2];
  assign out_ch.out_dir_x    = dir4_r[0];
  assign out_ch.out_dir_y    = dir4_r[1];
  assign out_ch.out_dir_z    = dir4_r[2];
  assign out_ch.saturated    = sat4_r;

endmodule

`default_nettype wire

@@ src/apvr_checker.sv @@
// Port-level checks for affine_point_vector_ray_transform, bound to the top.
// Depends only on the top level's channel ports.
`default_nettype none

module apvr_checker #(
  parameter int COORD_WIDTH = 32
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_origin_x,
  input wire logic [31:0] out_origin_y,
  input wire logic [31:0] out_origin_z,
  input wire logic [31:0] out_dir_x,
  input wire logic [31:0] out_dir_y,
  input wire logic [31:0] out_dir_z,
  input wire logic        saturated
);

  localparam logic [31:0] SAT_HI = 32'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
  localparam logic [31:0] SAT_LO = ~SAT_HI;

  function automatic logic at_bound(input logic [31:0] v);
    return (v == SAT_HI) || (v == SAT_LO);
  endfunction

  logic any_bound;
  assign any_bound = at_bound(out_origin_x) || at_bound(out_origin_y) ||
                     at_bound(out_origin_z) || at_bound(out_dir_x) ||
                     at_bound(out_dir_y) || at_bound(out_dir_z);

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word shown right after reset");

  // the input side only stalls behind a full pipe held by the output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  // a clipped component always sits on a range bound
  a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && saturated) |-> any_bound)
    else $error("saturated flag set with no component at a bound");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_origin_x) &&
      $stable(out_dir_x) && $stable(saturated)))
    else $error("stalled result word changed");

endmodule

bind affine_point_vector_ray_transform apvr_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_apvr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_origin_x (out_ch.out_origin_x),
  .out_origin_y (out_ch.out_origin_y),
  .out_origin_z (out_ch.out_origin_z),
  .out_dir_x    (out_ch.out_dir_x),
  .out_dir_y    (out_ch.out_dir_y),
  .out_dir_z    (out_ch.out_dir_z),
  .saturated    (out_ch.saturated)
);

`default_nettype wire

@@ tb/sv/affine_point_vector_ray_transform_tb.sv @@
// Self-checking bench for the 3x4 affine transform: directed corner cases, then
// random words under several matrix settings and idle/stall mixes.
// Depends on apvr_pkg, the channel interfaces in apvr_if.sv and the DUT.
`default_nettype none

module affine_point_vector_ray_transform_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     FRAC_BITS   = 16;
  localparam int     COORD_WIDTH = 32;
  localparam longint COORD_MAX   = (longint'(1) <<< (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_MIN   = -COORD_MAX - 1;

  localparam apvr_pkg::op_t      OP_UNDEF     = 2'd3;
  localparam apvr_pkg::reg_idx_t REG_SPARE_LO = 3'd6;
  localparam apvr_pkg::reg_idx_t REG_SPARE_HI = 3'd7;

  typedef logic [2:0][apvr_pkg::FIELD_W-1:0] coord3_t;  // [0] x, [1] y, [2] z

  typedef struct packed {
    apvr_pkg::op_t opcode;
    coord3_t       origin;
    coord3_t       dir;
  } xform_word_t;

  typedef struct packed {
    coord3_t origin;
    coord3_t dir;
    logic    saturated;
  } xform_result_t;

  typedef enum {MAT_SMALL, MAT_FULL, MAT_EXTREME} matrix_style_t;

  logic clk = 1'b0;
  logic rst_n;

  apvr_in_if  in_ch();
  apvr_out_if out_ch();
  apvr_cfg_if cfg_ch();

  affine_point_vector_ray_transform #(
    .FRAC_BITS  (FRAC_BITS),
    .COORD_WIDTH(COORD_WIDTH)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  logic [apvr_pkg::REG_W-1:0] matrix_regs [apvr_pkg::NUM_REGS];
  xform_result_t    expected_xforms [$];
  int               mismatch_count  = 0;
  int               in_idle_pct     = 0;
  int               out_idle_pct    = 0;
  int               hold_off_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void apply_matrix(input coord3_t v, input logic with_translation,
                                       output coord3_t res, inout logic clipped);
    longint                     c [3];
    longint                     acc;
    logic [apvr_pkg::REG_W-1:0] ra, rb;
    for (int k = 0; k < 3; k++) c[k] = longint'($signed(v[k][COORD_WIDTH-1:0]));
    for (int r = 0; r < 3; r++) begin
      ra  = matrix_regs[2*r];
      rb  = matrix_regs[2*r+1];
      // arithmetic shift of each product floors toward minus infinity
      acc = ((longint'($signed(ra[apvr_pkg::COEF_W-1:0])) * c[0]) >>> FRAC_BITS)
          + ((longint'($signed(ra[apvr_pkg::REG_W-1:apvr_pkg::COEF_W])) * c[1])
             >>> FRAC_BITS)
          + ((longint'($signed(rb[apvr_pkg::COEF_W-1:0])) * c[2]) >>> FRAC_BITS);
      if (with_translation)
        acc += longint'($signed(rb[apvr_pkg::REG_W-1:apvr_pkg::COEF_W]));
      if (acc > COORD_MAX) begin
        acc     = COORD_MAX;
        clipped = 1'b1;
      end else if (acc < COORD_MIN) begin
        acc     = COORD_MIN;
        clipped = 1'b1;
      end
      res[r] = apvr_pkg::FIELD_W'(acc);
    end
  endfunction

  function automatic xform_result_t transform_word(input xform_word_t w);
    xform_result_t r;
    logic          clipped;
    r       = '0;
    clipped = 1'b0;
    if (w.opcode == apvr_pkg::OP_POINT || w.opcode == apvr_pkg::OP_RAY)
      apply_matrix(w.origin, 1'b1, r.origin, clipped);
    if (w.opcode == apvr_pkg::OP_VECTOR || w.opcode == apvr_pkg::OP_RAY)
      apply_matrix(w.dir, 1'b0, r.dir, clipped);
    r.saturated = clipped;
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic xform_word_t mk_word(
    input apvr_pkg::op_t op,
    input logic [apvr_pkg::FIELD_W-1:0] ox, oy, oz, dx, dy, dz);
    xform_word_t w;
    w.opcode = op;
    w.origin = {oz, oy, ox};
    w.dir    = {dz, dy, dx};
    return w;
  endfunction

  function automatic logic [apvr_pkg::FIELD_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3, 4:    return $urandom;
      // +-32.0
      default: return apvr_pkg::FIELD_W'($urandom_range(0, 32'h3f_ffff)) - 32'h20_0000;
    endcase
  endfunction

  function automatic logic [apvr_pkg::COEF_W-1:0] rand_coef(input matrix_style_t style);
    case (style)
      MAT_FULL: return $urandom;
      MAT_EXTREME: begin
        case ($urandom_range(0, 4))
          0:       return 32'h7fff_ffff;
          1:       return 32'h8000_0000;
          2:       return '0;
          3:       return 32'hffff_ffff;
          default: return 32'h0001_0000;
        endcase
      end
      // +-4.0
      default: return apvr_pkg::COEF_W'($urandom_range(0, 32'h7_ffff)) - 32'h4_0000;
    endcase
  endfunction

  function automatic xform_word_t rand_word();
    apvr_pkg::op_t op;
    op = ($urandom_range(0, 19) == 0) ? OP_UNDEF :
         apvr_pkg::op_t'($urandom_range(apvr_pkg::OP_POINT, apvr_pkg::OP_RAY));
    return mk_word(op, rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord(), rand_coord());
  endfunction

  // ---------------------------------------------------------------- channel tasks

  task automatic send_word(input xform_word_t w);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= w.opcode;
    in_ch.origin_x <= w.origin[0];
    in_ch.origin_y <= w.origin[1];
    in_ch.origin_z <= w.origin[2];
    in_ch.dir_x    <= w.dir[0];
    in_ch.dir_y    <= w.dir[1];
    in_ch.dir_z    <= w.dir[2];
    do @(posedge clk); while (!in_ch.ready);
    expected_xforms.push_back(transform_word(w));
  endtask

  // drop valid, then wait until every accepted word has come back
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_xforms.size() != 0) @(posedge clk);
  endtask

  task automatic write_matrix_reg(input apvr_pkg::reg_idx_t idx,
                                  input logic [apvr_pkg::REG_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx < apvr_pkg::NUM_REGS) matrix_regs[idx] = val;  // out-of-range index is dropped
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic fill_matrix(input logic [apvr_pkg::REG_W-1:0] val);
    drain_results();
    for (int i = 0; i < apvr_pkg::NUM_REGS; i++)
      write_matrix_reg(apvr_pkg::reg_idx_t'(i), val);
  endtask

  task automatic load_matrix(input matrix_style_t style);
    drain_results();
    for (int i = 0; i < apvr_pkg::NUM_REGS; i++)
      write_matrix_reg(apvr_pkg::reg_idx_t'(i), {rand_coef(style), rand_coef(style)});
  endtask

  // ---------------------------------------------------------------- receiver / checker

  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_ch.ready    <= 1'b0;
      hold_off_cycles  = hold_off_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  task automatic check_field(input string name, input int k,
                             input logic [apvr_pkg::FIELD_W-1:0] want, got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t ns: %s[%0d] expected %h actual %h", $time, name, k, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    xform_result_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.origin[0] = out_ch.out_origin_x;
      got.origin[1] = out_ch.out_origin_y;
      got.origin[2] = out_ch.out_origin_z;
      got.dir[0]    = out_ch.out_dir_x;
      got.dir[1]    = out_ch.out_dir_y;
      got.dir[2]    = out_ch.out_dir_z;
      got.saturated = out_ch.saturated;
      if (expected_xforms.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result with nothing pending, expected none actual %h", $time, got);
      end else begin
        want = expected_xforms.pop_front();
        for (int k = 0; k < 3; k++) begin
          check_field("out_origin", k, want.origin[k], got.origin[k]);
          check_field("out_dir", k, want.dir[k], got.dir[k]);
        end
        check_field("saturated", 0, apvr_pkg::FIELD_W'(want.saturated),
                    apvr_pkg::FIELD_W'(got.saturated));
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // reset matrix is identity: results equal inputs, unused half zero
  task automatic identity_test();
    send_word(mk_word(apvr_pkg::OP_POINT, 32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678,
                      32'hdead_beef, 32'h0000_0001, 32'hffff_ffff));
    send_word(mk_word(apvr_pkg::OP_VECTOR, 32'h5555_aaaa, 32'h0f0f_0f0f, 32'h8000_0001,
                      32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff));
    send_word(mk_word(apvr_pkg::OP_RAY, 32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                      32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000));
    send_word(mk_word(OP_UNDEF, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                      32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    send_word(mk_word(apvr_pkg::OP_POINT, '0, '0, '0, '0, '0, '0));
  endtask

  task automatic saturation_test();
    fill_matrix(64'h7fff_ffff_7fff_ffff);
    send_word(mk_word(apvr_pkg::OP_POINT, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                      '0, '0, '0));
    send_word(mk_word(apvr_pkg::OP_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      '0, '0, '0));
    send_word(mk_word(apvr_pkg::OP_VECTOR, '0, '0, '0,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_word(mk_word(apvr_pkg::OP_RAY, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    // min coefficient times min coordinate is a large positive product
    fill_matrix(64'h8000_0000_8000_0000);
    send_word(mk_word(apvr_pkg::OP_POINT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      '0, '0, '0));
    send_word(mk_word(apvr_pkg::OP_VECTOR, '0, '0, '0,
                      32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
  endtask

  // tiny and zero coefficients: each negative product floors to -1, not 0
  task automatic rounding_test();
    fill_matrix(64'hffff_ffff_0000_0001);
    send_word(mk_word(apvr_pkg::OP_POINT, 32'hffff_ffff, 32'h0000_0001, 32'hffff_0001,
                      '0, '0, '0));
    send_word(mk_word(apvr_pkg::OP_VECTOR, '0, '0, '0,
                      32'h0001_0000, 32'hffff_0000, 32'h0000_ffff));
    fill_matrix('1);
    send_word(mk_word(apvr_pkg::OP_RAY, 32'h0000_0001, 32'h0000_0001, 32'h0000_0001,
                      32'hffff_ffff, 32'h0001_0000, 32'h0000_0000));
    fill_matrix('0);
    send_word(mk_word(apvr_pkg::OP_RAY, 32'h7fff_ffff, 32'h8000_0000, 32'h1357_9bdf,
                      32'h8000_0000, 32'h7fff_ffff, 32'h2468_ace0));
  endtask

  task automatic bad_index_test();
    load_matrix(MAT_SMALL);
    write_matrix_reg(REG_SPARE_LO, '1);
    write_matrix_reg(REG_SPARE_HI, {$urandom, $urandom});
    for (int i = 0; i < 3; i++) send_word(rand_word());
  endtask

  task automatic random_stream_test(input int n_items, input int in_pct, input int out_pct);
    in_idle_pct  = in_pct;
    out_idle_pct = out_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 45 == 0) load_matrix(matrix_style_t'($urandom_range(0, 2)));
      send_word(rand_word());
    end
  endtask

  // receiver goes quiet while the sender keeps offering: pipe fills, in ready drops
  task automatic backpressure_test();
    in_idle_pct  = 0;
    out_idle_pct = 0;
    load_matrix(MAT_SMALL);
    hold_off_cycles = 300;
    for (int i = 0; i < 40; i++) send_word(rand_word());
  endtask

  initial begin
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = apvr_pkg::OP_POINT;
    in_ch.origin_x = '0;
    in_ch.origin_y = '0;
    in_ch.origin_z = '0;
    in_ch.dir_x    = '0;
    in_ch.dir_y    = '0;
    in_ch.dir_z    = '0;
    out_ch.ready   = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = apvr_pkg::REG_ROW0_A;
    cfg_ch.data    = '0;
    matrix_regs[apvr_pkg::REG_ROW0_A] = apvr_pkg::RST_ROW0_A;
    matrix_regs[apvr_pkg::REG_ROW0_B] = apvr_pkg::RST_ROW0_B;
    matrix_regs[apvr_pkg::REG_ROW1_A] = apvr_pkg::RST_ROW1_A;
    matrix_regs[apvr_pkg::REG_ROW1_B] = apvr_pkg::RST_ROW1_B;
    matrix_regs[apvr_pkg::REG_ROW2_A] = apvr_pkg::RST_ROW2_A;
    matrix_regs[apvr_pkg::REG_ROW2_B] = apvr_pkg::RST_ROW2_B;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    identity_test();
    saturation_test();
    rounding_test();
    bad_index_test();
    random_stream_test(270, 20, 84);
    random_stream_test(270, 84, 20);
    random_stream_test(270, 0, 0);
    backpressure_test();

    drain_results();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_xforms.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
src/apvr_pkg.sv
src/apvr_if.sv
src/apvr_coef_regs.sv
src/apvr_row_pipe.sv
src/affine_point_vector_ray_transform.sv
src/apvr_checker.sv
tb/sv/affine_point_vector_ray_transform_tb.sv
